// File: design/eoff_pkg.sv
// Shared types, constants and helpers for the outlet face flux pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package eoff_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned GAMMA_W = 14;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 14'd5734;
  localparam int unsigned UN_Q_BITS = 31;
  localparam int unsigned KE_Q_BITS = 48;
  localparam int unsigned IN_DATA_W = 232;
  localparam int unsigned OUT_DATA_W = 184;
  localparam int unsigned OUT_USER_W = 2;

  typedef struct packed {
    logic [19:0]        tag;
    logic [30:0]        rho;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic signed [31:0] e;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } in_t;

  typedef struct packed {
    in_t                st;
    logic signed [31:0] mass;
    logic               sat;
    logic               un_neg;
    logic               un_ovf;
    logic               ke_ovf;
  } pay_t;

  typedef struct packed {
    logic [30:0] rho;
    logic [30:0] un_rem;
    logic [30:0] un_sh;
    logic [31:0] ke_rem;
    logic [47:0] ke_sh;
  } div_t;

  typedef struct packed {
    logic [19:0]        tag;
    logic signed [31:0] mass;
    logic signed [31:0] mfx;
    logic signed [31:0] mfy;
    logic signed [31:0] mfz;
    logic signed [31:0] ef;
    logic               pcl;
    logic               sat;
  } out_t;

  function automatic logic [31:0] sat32(input logic signed [64:0] x);
    if (x > 65'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (x < -65'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [64:0] x);
    return (x > 65'sd2147483647) || (x < -65'sd2147483648);
  endfunction

endpackage

// File: design/eoff_front.sv
// Front stages: input register, products, sums, divider setup and mass flux.
// Depends on eoff_pkg.
`timescale 1ns / 1ps

module eoff_front import eoff_pkg::*; #(
  parameter int unsigned FractionBits = FRACTION_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  in_t  data_i,
  output logic valid_o,
  output pay_t pay_o,
  output div_t div_o
);

  localparam int unsigned NW = 35 + FractionBits;

  logic v1_q, v2_q, v3_q, v4_q;
  in_t  s1_q, s2_q, s3_q, s1_d;

  logic signed [47:0] pmx_d, pmy_d, pmz_d, pmx_q, pmy_q, pmz_q;
  logic [31:0] ax, ay, az;
  logic [63:0] sqx_d, sqy_d, sqz_d, sqx_q, sqy_q, sqz_q;
  logic signed [49:0] mn_d, mn_q;
  logic [63:0] sq_d, sq_q;

  logic signed [34:0] mq;
  logic [34:0]        amq;
  logic [NW-1:0]      nun;
  logic [NW-32:0]     un_hi;
  logic [31:0]        d2;
  logic               un_ovf, ke_ovf, mass_sat;
  logic signed [31:0] mass;
  pay_t pay_d;
  div_t div_d;

  always_comb begin
    s1_d = data_i;
    if (data_i.rho == '0) begin
      s1_d.rho = 31'd1;
    end
  end

  assign ax = s1_q.mx[31] ? 32'(-s1_q.mx) : s1_q.mx;
  assign ay = s1_q.my[31] ? 32'(-s1_q.my) : s1_q.my;
  assign az = s1_q.mz[31] ? 32'(-s1_q.mz) : s1_q.mz;
  assign pmx_d = s1_q.mx * s1_q.nx;
  assign pmy_d = s1_q.my * s1_q.ny;
  assign pmz_d = s1_q.mz * s1_q.nz;
  assign sqx_d = 64'(ax) * 64'(ax);
  assign sqy_d = 64'(ay) * 64'(ay);
  assign sqz_d = 64'(az) * 64'(az);

  assign mn_d = 50'(pmx_q) + 50'(pmy_q) + 50'(pmz_q);
  assign sq_d = sqx_q + sqy_q + sqz_q;

  always_comb begin
    mq       = 35'(mn_q >>> 15);
    mass_sat = (mq > 35'sd2147483647) || (mq < -35'sd2147483648);
    if (mq > 35'sd2147483647) begin
      mass = 32'sh7fff_ffff;
    end else if (mq < -35'sd2147483648) begin
      mass = 32'sh8000_0000;
    end else begin
      mass = mq[31:0];
    end
    amq    = mq[34] ? 35'(-mq) : mq;
    nun    = {amq, {FractionBits{1'b0}}};
    un_hi  = nun[NW-1:31];
    un_ovf = 64'(un_hi) >= 64'(s3_q.rho);
    d2     = {s3_q.rho, 1'b0};
    ke_ovf = {16'd0, sq_q[63:48]} >= d2;

    pay_d.st     = s3_q;
    pay_d.mass   = mass;
    pay_d.sat    = mass_sat;
    pay_d.un_neg = mq[34];
    pay_d.un_ovf = un_ovf;
    pay_d.ke_ovf = ke_ovf;

    div_d.rho    = s3_q.rho;
    div_d.un_rem = un_ovf ? '0 : 31'(un_hi);
    div_d.un_sh  = nun[30:0];
    div_d.ke_rem = ke_ovf ? '0 : {16'd0, sq_q[63:48]};
    div_d.ke_sh  = sq_q[47:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      s2_q  <= s1_q;
      pmx_q <= pmx_d;
      pmy_q <= pmy_d;
      pmz_q <= pmz_d;
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      sqz_q <= sqz_d;
      s3_q  <= s2_q;
      mn_q  <= mn_d;
      sq_q  <= sq_d;
      pay_o <= pay_d;
      div_o <= div_d;
    end
  end

  assign valid_o = v4_q;

endmodule

// File: design/eoff_div_stage.sv
// One quotient bit of the kinetic-energy restoring divider, and of the normal velocity divider while Step < UN_Q_BITS.
// Depends on eoff_pkg.
`timescale 1ns / 1ps

module eoff_div_stage import eoff_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  pay_t pay_i,
  input  div_t div_i,
  output logic valid_o,
  output pay_t pay_o,
  output div_t div_o
);

  logic [31:0] un_t;
  logic        un_ge;
  logic [32:0] ke_t, ke_dv;
  logic        ke_ge;
  logic        v_q;
  div_t        div_d;

  always_comb begin
    div_d = div_i;
    ke_dv = {1'b0, div_i.rho, 1'b0};
    ke_t  = {div_i.ke_rem, div_i.ke_sh[47]};
    ke_ge = ke_t >= ke_dv;
    div_d.ke_rem = ke_ge ? 32'(ke_t - ke_dv) : ke_t[31:0];
    div_d.ke_sh  = {div_i.ke_sh[46:0], ke_ge};
    un_t  = {div_i.un_rem, div_i.un_sh[30]};
    un_ge = un_t >= {1'b0, div_i.rho};
    if (Step < UN_Q_BITS) begin
      div_d.un_rem = un_ge ? 31'(un_t - {1'b0, div_i.rho}) : un_t[30:0];
      div_d.un_sh  = {div_i.un_sh[29:0], un_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_o <= pay_i;
      div_o <= div_d;
    end
  end

  assign valid_o = v_q;

endmodule

// File: design/eoff_divider.sv
// Chain of divider stages, one quotient bit per register stage.
// Depends on eoff_pkg and eoff_div_stage.
`timescale 1ns / 1ps

module eoff_divider import eoff_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  pay_t pay_i,
  input  div_t div_i,
  output logic valid_o,
  output pay_t pay_o,
  output div_t div_o
);

  logic [KE_Q_BITS:0] v;
  pay_t pay [KE_Q_BITS+1];
  div_t dv  [KE_Q_BITS+1];

  assign v[0]   = valid_i;
  assign pay[0] = pay_i;
  assign dv[0]  = div_i;

  for (genvar k = 0; k < KE_Q_BITS; k++) begin : g_stage
    eoff_div_stage #(.Step(k)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (v[k]),
      .pay_i   (pay[k]),
      .div_i   (dv[k]),
      .valid_o (v[k+1]),
      .pay_o   (pay[k+1]),
      .div_o   (dv[k+1])
    );
  end

  assign valid_o = v[KE_Q_BITS];
  assign pay_o   = pay[KE_Q_BITS];
  assign div_o   = dv[KE_Q_BITS];

endmodule

// File: design/eoff_back.sv
// Back stages: pressure, flux products, final sums, saturation, output register.
// Depends on eoff_pkg.
`timescale 1ns / 1ps

module eoff_back import eoff_pkg::*; #(
  parameter int unsigned FractionBits = FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  pay_t               pay_i,
  input  div_t               div_i,
  input  logic [GAMMA_W-1:0] gamma_i,
  output logic               valid_o,
  output out_t               out_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // stage 1
  logic [30:0]        umag;
  logic signed [31:0] un_d, un1_q;
  logic [48:0]        ke;
  logic signed [49:0] dd;
  logic signed [48:0] d_d, d1_q;
  pay_t               p1_d, p1_q;

  // stage 2
  logic signed [14:0] gm1;
  logic signed [63:0] praw_d, praw_q;
  logic signed [63:0] mux_d, muy_d, muz_d, eun_d;
  logic signed [63:0] mux2_q, muy2_q, muz2_q, eun2_q;
  logic signed [31:0] un2_q;
  pay_t               p2_q;

  // stage 3
  logic signed [63:0] ps;
  logic signed [31:0] pr_d, pr3_q;
  logic               pcl_d, psat_d, pcl3_q, psat3_q;
  logic signed [63:0] mux3_q, muy3_q, muz3_q, eun3_q;
  logic signed [31:0] un3_q;
  pay_t               p3_q;

  // stage 4
  logic signed [47:0] pnx4_q, pny4_q, pnz4_q;
  logic signed [63:0] pun4_q;
  logic signed [63:0] mux4_q, muy4_q, muz4_q, eun4_q;
  logic               pcl4_q, psat4_q;
  pay_t               p4_q;

  // stage 5
  logic signed [64:0] tx, ty, tz, tes, te;
  out_t               out_d;

  always_comb begin
    umag = pay_i.un_ovf ? 31'h7fff_ffff : div_i.un_sh;
    un_d = pay_i.un_neg ? -$signed({1'b0, umag}) : $signed({1'b0, umag});
    ke   = pay_i.ke_ovf ? 49'h1_0000_0000_0000 : {1'b0, div_i.ke_sh};
    dd   = 50'(pay_i.st.e) - $signed(50'(ke));
    d_d  = (dd < -50'sd140737488355328) ? -49'sd140737488355328 : 49'(dd);
    p1_d     = pay_i;
    p1_d.sat = pay_i.sat | pay_i.un_ovf;
  end

  assign gm1    = $signed({1'b0, gamma_i}) - 15'sd4096;
  assign praw_d = gm1 * d1_q;
  assign mux_d  = p1_q.st.mx * un1_q;
  assign muy_d  = p1_q.st.my * un1_q;
  assign muz_d  = p1_q.st.mz * un1_q;
  assign eun_d  = p1_q.st.e * un1_q;

  always_comb begin
    ps     = praw_q >>> 12;
    pcl_d  = 1'b0;
    psat_d = 1'b0;
    pr_d   = ps[31:0];
    if (ps < 0) begin
      pr_d  = 32'sd1;
      pcl_d = 1'b1;
    end else if (ps > 64'sd2147483647) begin
      pr_d   = 32'sh7fff_ffff;
      psat_d = 1'b1;
    end
  end

  always_comb begin
    tx  = 65'(pnx4_q >>> 15) + 65'(mux4_q >>> FractionBits);
    ty  = 65'(pny4_q >>> 15) + 65'(muy4_q >>> FractionBits);
    tz  = 65'(pnz4_q >>> 15) + 65'(muz4_q >>> FractionBits);
    tes = 65'(eun4_q) + 65'(pun4_q);
    te  = tes >>> FractionBits;
    out_d.tag  = p4_q.st.tag;
    out_d.mass = p4_q.mass;
    out_d.mfx  = sat32(tx);
    out_d.mfy  = sat32(ty);
    out_d.mfz  = sat32(tz);
    out_d.ef   = sat32(te);
    out_d.pcl  = pcl4_q;
    out_d.sat  = p4_q.sat | psat4_q | ovf32(tx) | ovf32(ty) | ovf32(tz) | ovf32(te);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q      <= p1_d;
      un1_q     <= un_d;
      d1_q      <= d_d;

      p2_q      <= p1_q;
      un2_q     <= un1_q;
      praw_q    <= praw_d;
      mux2_q    <= mux_d;
      muy2_q    <= muy_d;
      muz2_q    <= muz_d;
      eun2_q    <= eun_d;

      p3_q      <= p2_q;
      un3_q     <= un2_q;
      pr3_q     <= pr_d;
      pcl3_q    <= pcl_d;
      psat3_q   <= psat_d;
      mux3_q    <= mux2_q;
      muy3_q    <= muy2_q;
      muz3_q    <= muz2_q;
      eun3_q    <= eun2_q;

      p4_q      <= p3_q;
      pnx4_q    <= pr3_q * p3_q.st.nx;
      pny4_q    <= pr3_q * p3_q.st.ny;
      pnz4_q    <= pr3_q * p3_q.st.nz;
      pun4_q    <= pr3_q * un3_q;
      mux4_q    <= mux3_q;
      muy4_q    <= muy3_q;
      muz4_q    <= muz3_q;
      eun4_q    <= eun3_q;
      pcl4_q    <= pcl3_q;
      psat4_q   <= psat3_q;

      out_o     <= out_d;
    end
  end

  assign valid_o = v5_q;

endmodule

// File: design/euler_outlet_face_flux.sv
// Top level of the outlet face flux block: stream ports, gamma register, pipeline.
// Depends on eoff_pkg, eoff_front, eoff_divider, eoff_back.
`timescale 1ns / 1ps

// Euler flux across one outlet face per transaction, fully pipelined: one face
// is accepted every cycle while the output is not stalled, and each result passes
// through 4 front stages, 48 divider stages and 5 back stages. The depth is set by the
// kinetic-energy divide, which retires one quotient bit per stage; the normal
// velocity divide runs alongside it in the first 31 of those stages. When the result is not
// taken the whole pipeline holds. gas_gamma may be written only while no face is
// in flight; the write channel is always ready.

module euler_outlet_face_flux import eoff_pkg::*; #(
  parameter int unsigned FractionBits = FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // face_index, density, momentum_x, momentum_y, momentum_z, total_energy,
  // normal_x, normal_y, normal_z, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // face_tag, mass_flux, momentum_flux_x, momentum_flux_y, momentum_flux_z,
  // energy_flux, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // pressure_clamped, saturated
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [GAMMA_W-1:0]    cfg_data_i
);

  logic               en;
  logic [GAMMA_W-1:0] gamma_q;
  in_t                in_s;
  logic               fv, dv, bv;
  pay_t               fpay, dpay;
  div_t               fdiv, ddiv;
  out_t               res;

  assign en              = !bv | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GAMMA_RESET;
    end else if (cfg_valid_i) begin
      gamma_q <= cfg_data_i;
    end
  end

  assign in_s.tag = s_axis_tdata_i[19:0];
  assign in_s.rho = s_axis_tdata_i[50:20];
  assign in_s.mx  = s_axis_tdata_i[82:51];
  assign in_s.my  = s_axis_tdata_i[114:83];
  assign in_s.mz  = s_axis_tdata_i[146:115];
  assign in_s.e   = s_axis_tdata_i[178:147];
  assign in_s.nx  = s_axis_tdata_i[194:179];
  assign in_s.ny  = s_axis_tdata_i[210:195];
  assign in_s.nz  = s_axis_tdata_i[226:211];

  eoff_front #(.FractionBits(FractionBits)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .data_i  (in_s),
    .valid_o (fv),
    .pay_o   (fpay),
    .div_o   (fdiv)
  );

  eoff_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .pay_i   (fpay),
    .div_i   (fdiv),
    .valid_o (dv),
    .pay_o   (dpay),
    .div_o   (ddiv)
  );

  eoff_back #(.FractionBits(FractionBits)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .pay_i   (dpay),
    .div_i   (ddiv),
    .gamma_i (gamma_q),
    .valid_o (bv),
    .out_o   (res)
  );

  assign m_axis_tvalid_o = bv;
  assign m_axis_tdata_o  = {4'd0, res.ef, res.mfz, res.mfy, res.mfx, res.mass, res.tag};
  assign m_axis_tuser_o  = {res.sat, res.pcl};

endmodule

// File: design/eoff_checker.sv
// Port-level checks for the outlet face flux block, bound to the top level.
// Depends on eoff_pkg and euler_outlet_face_flux.
`timescale 1ns / 1ps

module eoff_checker import eoff_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_USER_W-1:0] m_axis_tuser_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [GAMMA_W-1:0]    cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[183:180] == 4'd0) && cfg_ready_o)
    else $error("pad bits set or config not ready");

endmodule

bind euler_outlet_face_flux eoff_checker u_eoff_checker (.*);
